/* sv/lbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the 3x3 local binary pattern operator.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int PIX_W         = 8;
	localparam int CFG_W         = 12;
	localparam int ROW_W         = 12;
	localparam int MAX_WIDTH_DEF = 2048;

	// APB register file
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic       REG_IMAGE_WIDTH  = 1'b0;
	localparam logic       REG_IMAGE_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

	// code bit positions, clockwise from top-left
	localparam int BIT_TOP_LEFT     = 7;
	localparam int BIT_TOP          = 6;
	localparam int BIT_TOP_RIGHT    = 5;
	localparam int BIT_RIGHT        = 4;
	localparam int BIT_BOTTOM_RIGHT = 3;
	localparam int BIT_BOTTOM       = 2;
	localparam int BIT_BOTTOM_LEFT  = 1;
	localparam int BIT_LEFT         = 0;

	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
	} cfg_t;

	// pixel request in flight between line store read and window update
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             produce;
		logic             row_end;
		logic             frame_end;
	} s1_ctl_t;

	// two line store rows packed in one memory word
	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] newer;
	} line_pair_t;

endpackage
`default_nettype wire

/* sv/lbp_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_ifs
// Valid/ready stream interfaces for pixel input and code output.
// ----------------------------------------------------------------------------
interface lbp_pix_if;
	import lbp_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;
	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface lbp_code_if;
	import lbp_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] code;
	logic             row_end;
	logic             frame_end;
	modport source (output valid, output code, output row_end, output frame_end, input ready);
	modport sink   (input valid, input code, input row_end, input frame_end, output ready);
endinterface
`default_nettype wire

/* sv/lbp_cfg_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_cfg_regs
// APB register file holding image width and image height.
// ----------------------------------------------------------------------------
module lbp_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [lbp_pkg::APB_AW-1:0]  paddr,
	input  wire logic [lbp_pkg::APB_DW-1:0]  pwdata,
	output logic      [lbp_pkg::APB_DW-1:0]  prdata,
	output logic                             pready,
	output lbp_pkg::cfg_t                    cfg
);
	import lbp_pkg::*;

	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// write registers on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.image_width  <= WIDTH_RESET;
			cfg.image_height <= HEIGHT_RESET;
		end else if (wr_en) begin
			if (reg_sel == REG_IMAGE_WIDTH) begin
				cfg.image_width <= pwdata[CFG_W-1:0];
			end else begin
				cfg.image_height <= pwdata[CFG_W-1:0];
			end
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_sel == REG_IMAGE_WIDTH) begin
			prdata[CFG_W-1:0] = cfg.image_width;
		end else begin
			prdata[CFG_W-1:0] = cfg.image_height;
		end
	end

endmodule
`default_nettype wire

/* sv/lbp_line_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_line_mem
// Line store: both previous rows in one word, one read and one write port,
// registered read data with write-to-read bypass on a same-address collision.
// ----------------------------------------------------------------------------
module lbp_line_mem #(
	parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output lbp_pkg::line_pair_t      rd_data,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire lbp_pkg::line_pair_t wr_data
);
	import lbp_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t ram_q;
	line_pair_t byp_data_q;
	logic       byp_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			ram_q      <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// flag a read that collides with the write of the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : ram_q;

endmodule
`default_nettype wire

/* sv/lbp_window.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_window
// 3x3 window columns and the eight neighbor comparisons against the center.
// ----------------------------------------------------------------------------
module lbp_window (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire lbp_pkg::s1_ctl_t              ctl,
	input  wire logic [lbp_pkg::PIX_W-1:0]     top,
	input  wire logic [lbp_pkg::PIX_W-1:0]     mid,
	output logic      [lbp_pkg::PIX_W-1:0]     code
);
	import lbp_pkg::*;

	// 0..2: column c-2, 3..5: column c-1; top, middle, bottom
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] ctr;

	// shift the window by one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= ctl.pixel;
		end
	end

	// compare neighbors against the center
	assign ctr = win_q[4];
	always_comb begin
		code                   = '0;
		code[BIT_TOP_LEFT]     = win_q[0] > ctr;
		code[BIT_TOP]          = win_q[3] > ctr;
		code[BIT_TOP_RIGHT]    = top > ctr;
		code[BIT_RIGHT]        = mid > ctr;
		code[BIT_BOTTOM_RIGHT] = ctl.pixel > ctr;
		code[BIT_BOTTOM]       = win_q[5] > ctr;
		code[BIT_BOTTOM_LEFT]  = win_q[2] > ctr;
		code[BIT_LEFT]         = win_q[1] > ctr;
	end

endmodule
`default_nettype wire

/* sv/lbp_3x3_operator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lbp_3x3_operator
// Streaming 3x3 local binary pattern operator over raster-order grey pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle while the code output is not
// stalled, and gives one 8-bit code for every interior center pixel once
// its bottom-right neighbor is taken, via the line store read and the output
// register. The rate is set by the line store memory, which serves one read
// (at accept) and one write (as the request leaves the read stage) per cycle.
// The line store needs no clearing pass after reset; the first two rows of a
// frame fill it. Border pixels give no code, so a frame of H rows by W pixels
// gives (H-2) by (W-2) codes, row_end and frame_end marking the last code of
// a row and of the frame. Widths below 3 act as 3, above MAX_WIDTH as
// MAX_WIDTH; heights below 3 act as 3. A frame wraps on its own after its
// last pixel; frame_start restarts the position at any pixel.
// ----------------------------------------------------------------------------
module lbp_3x3_operator #(
	parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [lbp_pkg::APB_AW-1:0] paddr,
	input  wire logic [lbp_pkg::APB_DW-1:0] pwdata,
	output logic      [lbp_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	lbp_pix_if.sink                         pixels,
	lbp_code_if.source                      codes
);
	import lbp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = 14;

	cfg_t             cfg;
	logic [XW-1:0]    width_x;
	logic [CW-1:0]    width_last;
	logic [ROW_W-1:0] height_last;

	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_cur;
	logic [ROW_W-1:0] row_cur;
	logic             at_row_end;
	logic             at_frame_end;
	logic             accept;

	logic             s1_valid_q;
	s1_ctl_t          ctl_s1;
	logic [CW-1:0]    addr_s1;
	logic             s1_adv;

	line_pair_t       line_rd;
	line_pair_t       line_wr;
	logic [PIX_W-1:0] code_calc;

	logic             out_valid_q;
	logic [PIX_W-1:0] code_q;
	logic             row_end_q;
	logic             frame_end_q;

	lbp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamp the geometry to its working range
	assign width_x = XW'(cfg.image_width);
	always_comb begin
		if (width_x < XW'(3)) begin
			width_last = CW'(2);
		end else if (width_x > XW'(MAX_WIDTH)) begin
			width_last = CW'(MAX_WIDTH - 1);
		end else begin
			width_last = CW'(width_x - XW'(1));
		end
		if (cfg.image_height < ROW_W'(3)) begin
			height_last = ROW_W'(2);
		end else begin
			height_last = cfg.image_height - ROW_W'(1);
		end
	end

	// position of the incoming pixel
	assign col_cur      = pixels.frame_start ? '0 : col_q;
	assign row_cur      = pixels.frame_start ? '0 : row_q;
	assign at_row_end   = col_cur >= width_last;
	assign at_frame_end = at_row_end && (row_cur >= height_last);

	assign s1_adv       = s1_valid_q && (!ctl_s1.produce || !out_valid_q || codes.ready);
	assign pixels.ready = !s1_valid_q || s1_adv;
	assign accept       = pixels.valid && pixels.ready;

	// advance the raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_row_end) begin
				col_q <= '0;
				row_q <= at_frame_end ? '0 : row_cur + ROW_W'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// read stage: hold the request while the line store answers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pixels.ready) begin
			s1_valid_q <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.pixel     <= pixels.pixel;
			ctl_s1.produce   <= (row_cur >= ROW_W'(2)) && (col_cur >= CW'(2));
			ctl_s1.row_end   <= at_row_end;
			ctl_s1.frame_end <= at_frame_end;
			addr_s1          <= col_cur;
		end
	end

	// shift the rows down as the request leaves the read stage
	assign line_wr.older = line_rd.newer;
	assign line_wr.newer = ctl_s1.pixel;

	lbp_line_mem #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.rd_data (line_rd),
		.wr_en   (s1_adv),
		.wr_addr (addr_s1),
		.wr_data (line_wr)
	);

	lbp_window u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (s1_adv),
		.ctl    (ctl_s1),
		.top    (line_rd.older),
		.mid    (line_rd.newer),
		.code   (code_calc)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctl_s1.produce) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.produce) begin
			code_q      <= code_calc;
			row_end_q   <= ctl_s1.row_end;
			frame_end_q <= ctl_s1.frame_end;
		end
	end

	assign codes.valid     = out_valid_q;
	assign codes.code      = code_q;
	assign codes.row_end   = row_end_q;
	assign codes.frame_end = frame_end_q;

	// a frame start always lands on column zero, which never ends a row
	a_frame_start_col : assert property (@(posedge clk) disable iff (!arst_n)
		accept && pixels.frame_start |=> col_q == CW'(1))
		else $error("column did not advance after frame start");

	// a stalled read stage blocks new requests
	a_stall_blocks : assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |-> !accept)
		else $error("request taken while read stage stalled");

	// a produced code always reaches the output register
	a_code_lands : assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && ctl_s1.produce |=> out_valid_q)
		else $error("code lost between read stage and output");

endmodule
`default_nettype wire
